/* rtl/clist_pkg.sv */
// ----------------------------------------------------------------------------
// clist_pkg
// Shared types and fixed widths of the circular list engine.
// ----------------------------------------------------------------------------
package clist_pkg;

	localparam int REQ_W    = 2;
	localparam int STATUS_W = 2;
	localparam int ENTRY_W  = 32;
	localparam int COUNT_W  = 5;

	typedef enum logic [REQ_W-1:0] {
		REQ_INS_FRONT = 2'd0,
		REQ_INS_END   = 2'd1,
		REQ_DELETE    = 2'd2,
		REQ_DUMP      = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_NOT_FOUND = 2'd2,
		STS_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_NODE,
		S_INS_LINK,
		S_DEL_WALK,
		S_DUMP,
		S_RESP
	} state_t;

	// field write enables of the node memory
	typedef struct packed {
		logic value;
		logic link;
	} node_we_t;

	// free-slot stack operations
	typedef struct packed {
		logic rd;    // read the top entry
		logic pop;   // commit the pop of the entry read
		logic push;  // push a released slot
	} free_op_t;

	typedef struct packed {
		status_t                     status;
		logic signed [ENTRY_W-1:0]   value;
		logic                        last;
		logic        [COUNT_W-1:0]   count;
	} result_t;

endpackage

/* rtl/clist_node_mem.sv */
// ----------------------------------------------------------------------------
// clist_node_mem
// Slot store: value and next link per slot, field write enables,
// registered read port.
// ----------------------------------------------------------------------------
module clist_node_mem import clist_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [$clog2(CAPACITY)-1:0] rd_addr,
	output logic [VALUE_BITS-1:0]       rd_value,
	output logic [$clog2(CAPACITY)-1:0] rd_link,
	input  node_we_t                    we,
	input  logic [$clog2(CAPACITY)-1:0] wr_addr,
	input  logic [VALUE_BITS-1:0]       wr_value,
	input  logic [$clog2(CAPACITY)-1:0] wr_link
);

	localparam int AW = $clog2(CAPACITY);
	localparam int NW = VALUE_BITS + AW;

	logic [NW-1:0] mem [CAPACITY];
	logic [NW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we.value) begin
			mem[wr_addr][NW-1:AW] <= wr_value;
		end
		if (we.link) begin
			mem[wr_addr][AW-1:0] <= wr_link;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign rd_value = rdata_q[NW-1:AW];
	assign rd_link  = rdata_q[AW-1:0];

endmodule

/* rtl/clist_free_stack.sv */
// ----------------------------------------------------------------------------
// clist_free_stack
// Stack of free slot indexes in a memory. Entries below the low-water
// mark were never written and read as their own index.
// ----------------------------------------------------------------------------
module clist_free_stack import clist_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  free_op_t                    op,
	input  logic [$clog2(CAPACITY)-1:0] push_slot,
	output logic [$clog2(CAPACITY)-1:0] pop_slot
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [AW-1:0] mem [CAPACITY];
	logic [AW-1:0] rdata_q;
	logic [AW-1:0] idx_s1;
	logic [CW-1:0] top_q;
	logic [CW-1:0] mark_q;
	logic [CW-1:0] top_m1;
	logic          fresh;

	assign top_m1   = top_q - CW'(1);
	assign fresh    = CW'(idx_s1) < mark_q;
	assign pop_slot = fresh ? idx_s1 : rdata_q;

	always_ff @(posedge clk) begin
		if (op.push) begin
			mem[top_q[AW-1:0]] <= push_slot;
		end
		if (op.rd) begin
			rdata_q <= mem[top_m1[AW-1:0]];
			idx_s1  <= top_m1[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q  <= CW'(CAPACITY);
			mark_q <= CW'(CAPACITY);
		end else begin
			if (op.pop) begin
				top_q <= top_m1;
				if (fresh) begin
					mark_q <= CW'(idx_s1);
				end
			end else if (op.push) begin
				top_q <= top_q + CW'(1);
			end
		end
	end

endmodule

/* rtl/clist_out_reg.sv */
// ----------------------------------------------------------------------------
// clist_out_reg
// Result register on the output channel.
// ----------------------------------------------------------------------------
module clist_out_reg import clist_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  result_t                    item,
	output logic                       free,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [STATUS_W-1:0]        status,
	output logic signed [ENTRY_W-1:0]  entry_value,
	output logic                       last,
	output logic [COUNT_W-1:0]         entry_count
);

	logic    valid_q;
	result_t item_q;

	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			item_q <= item;
		end
	end

	assign out_valid   = valid_q;
	assign status      = item_q.status;
	assign entry_value = item_q.value;
	assign last        = item_q.last;
	assign entry_count = item_q.count;

endmodule

/* rtl/circular_list_engine.sv */
// ----------------------------------------------------------------------------
// circular_list_engine
// Bounded circular singly linked list: insert at front or end, delete by
// key, dump from head. Nodes and the free-slot stack live in memories.
// ----------------------------------------------------------------------------
// Sequence: an insert reads the free stack, writes the node, then links the ring
//   (not into an empty list) and replies; a refused insert or an empty-list
//   request replies directly; delete walks to a match or the list end; dump
//   streams entries from the head. Throughput: one transaction at a time; walks
//   read one node per cycle, a dump only while the output register is free.
// Reset: list empty, free stack full; the stack low-water mark replaces a clearing pass.
module circular_list_engine import clist_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [REQ_W-1:0]           req_type,
	input  logic signed [ENTRY_W-1:0]  item_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [STATUS_W-1:0]        status,
	output logic signed [ENTRY_W-1:0]  entry_value,
	output logic                       last,
	output logic [COUNT_W-1:0]         entry_count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	// control state
	state_t        state_q, state_d;
	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;

	// per-transaction registers
	req_t                  req_q;
	logic [VALUE_BITS-1:0] key_q;
	status_t               status_q;
	logic [AW-1:0]         cur_q, prev_q, slot_q;
	logic [CW-1:0]         idx_q;

	// datapath nets
	logic                  in_fire;
	req_t                  req_in;
	logic [VALUE_BITS-1:0] key_in;
	logic                  is_full, is_empty;
	logic                  match, walk_end, out_free;

	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [VALUE_BITS-1:0] rd_value;
	logic [AW-1:0]         rd_link;
	node_we_t              node_we;
	logic [AW-1:0]         wr_addr;
	logic [VALUE_BITS-1:0] wr_value;
	logic [AW-1:0]         wr_link;

	free_op_t              free_op;
	logic [AW-1:0]         pop_slot;

	logic                  out_load;
	result_t               out_item;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign req_in   = req_t'(req_type);
	// values are held sign-extended or truncated to VALUE_BITS
	assign key_in   = VALUE_BITS'(item_value);
	assign is_full  = (count_q == CW'(CAPACITY));
	assign is_empty = (count_q == '0);
	assign match    = (rd_value == key_q);
	assign walk_end = (idx_q + CW'(1) == count_q);

	clist_node_mem #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_node_mem (
		.clk      (clk),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_value (rd_value),
		.rd_link  (rd_link),
		.we       (node_we),
		.wr_addr  (wr_addr),
		.wr_value (wr_value),
		.wr_link  (wr_link)
	);

	clist_free_stack #(
		.CAPACITY (CAPACITY)
	) u_free_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (free_op),
		.push_slot (cur_q),
		.pop_slot  (pop_slot)
	);

	clist_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (out_load),
		.item        (out_item),
		.free        (out_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.entry_value (entry_value),
		.last        (last),
		.entry_count (entry_count)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					case (req_in)
						REQ_INS_FRONT, REQ_INS_END: state_d = is_full ? S_RESP : S_INS_RD;
						REQ_DELETE:                 state_d = is_empty ? S_RESP : S_DEL_WALK;
						default:                    state_d = is_empty ? S_RESP : S_DUMP;
					endcase
				end
			end
			S_INS_RD:   state_d = S_INS_NODE;
			S_INS_NODE: state_d = is_empty ? S_RESP : S_INS_LINK;
			S_INS_LINK: state_d = S_RESP;
			S_DEL_WALK: begin
				if (match || walk_end) begin
					state_d = S_RESP;
				end
			end
			S_DUMP: begin
				if (out_free && walk_end) begin
					state_d = S_IDLE;
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory controls and result
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = rd_link;
		node_we  = '0;
		wr_addr  = prev_q;
		wr_value = key_q;
		wr_link  = rd_link;
		free_op  = '0;
		out_load = 1'b0;
		out_item = '{status: status_q, value: '0, last: 1'b1,
			count: COUNT_W'(count_q)};
		case (state_q)
			S_IDLE: begin
				// first node read of a walk goes out with the accept
				rd_en   = in_fire && (req_in == REQ_DELETE || req_in == REQ_DUMP);
				rd_addr = head_q;
			end
			S_INS_RD: begin
				free_op.rd = 1'b1;
			end
			S_INS_NODE: begin
				free_op.pop   = 1'b1;
				node_we.value = 1'b1;
				node_we.link  = 1'b1;
				wr_addr       = pop_slot;
				wr_link       = is_empty ? pop_slot : head_q;
			end
			S_INS_LINK: begin
				// close the ring through the new slot
				node_we.link = 1'b1;
				wr_addr      = tail_q;
				wr_link      = slot_q;
			end
			S_DEL_WALK: begin
				if (match) begin
					// unlink cur; the link write is skipped when it was the only entry
					node_we.link = (count_q != CW'(1));
					free_op.push = 1'b1;
				end else if (!walk_end) begin
					rd_en = 1'b1;
				end
			end
			S_DUMP: begin
				if (out_free) begin
					out_load       = 1'b1;
					out_item.value = ENTRY_W'(rd_value);
					out_item.last  = walk_end;
					out_item.status = STS_OK;
					rd_en          = !walk_end;
				end
			end
			S_RESP: begin
				out_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_INS_NODE: begin
					if (is_empty) begin
						head_q  <= pop_slot;
						tail_q  <= pop_slot;
						count_q <= count_q + CW'(1);
					end
				end
				S_INS_LINK: begin
					if (req_q == REQ_INS_FRONT) begin
						head_q <= slot_q;
					end else begin
						tail_q <= slot_q;
					end
					count_q <= count_q + CW'(1);
				end
				S_DEL_WALK: begin
					if (match) begin
						if (count_q == CW'(1)) begin
							head_q <= '0;
							tail_q <= '0;
						end else begin
							if (cur_q == head_q) begin
								head_q <= rd_link;
							end
							if (cur_q == tail_q) begin
								tail_q <= prev_q;
							end
						end
						count_q <= count_q - CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					req_q  <= req_in;
					key_q  <= key_in;
					cur_q  <= head_q;
					prev_q <= tail_q;
					idx_q  <= '0;
					case (req_in)
						REQ_INS_FRONT, REQ_INS_END: status_q <= is_full ? STS_FULL : STS_OK;
						REQ_DELETE:                 status_q <= STS_NOT_FOUND;
						default:                    status_q <= STS_EMPTY;
					endcase
				end
			end
			S_INS_NODE: begin
				slot_q <= pop_slot;
			end
			S_DEL_WALK: begin
				if (match) begin
					status_q <= STS_OK;
				end else begin
					prev_q <= cur_q;
					cur_q  <= rd_link;
					idx_q  <= idx_q + CW'(1);
				end
			end
			S_DUMP: begin
				if (out_free) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			default: ;
		endcase
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_link_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS_LINK |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not add an entry");

	a_walk_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEL_WALK || state_q == S_DUMP) |-> idx_q < count_q)
		else $error("walk ran past the list");

	a_no_read_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		(node_we.link || node_we.value) |-> !rd_en)
		else $error("node read collides with a write");

	a_dump_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP && !out_free) |=> state_q == S_DUMP && $stable(idx_q))
		else $error("dump advanced while output stalled");

endmodule

/* bench/tb_circular_list_engine.sv */
// ----------------------------------------------------------------------------
// tb_circular_list_engine
// Self-checking bench for the bounded circular list engine. It runs a set of
// directed list operations, a fill under a long output stall, and biased
// random traffic. A behavioral copy of the list predicts every reply, and
// each reply is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_circular_list_engine;
	import clist_pkg::*;

	localparam int CAP           = 16;
	localparam int IDX_W         = $clog2(CAP);
	localparam int HOLD_CYCLES   = 400;       // long output stall, in cycles
	localparam int QUIET_LIMIT   = 3000;      // cycles with no transaction at all
	localparam int SETTLE_CYCLES = CAP + 8;   // longest walk plus response slack
	localparam int REPORT_MAX    = 10;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [REQ_W-1:0]           req_type;
	logic signed [ENTRY_W-1:0]  item_value;
	logic                       out_valid;
	logic                       out_ready;
	logic [STATUS_W-1:0]        status;
	logic signed [ENTRY_W-1:0]  entry_value;
	logic                       last;
	logic [COUNT_W-1:0]         entry_count;

	// Shadow copy of the list: node values, next links, spare-slot stack,
	// head/tail pointers and the entry count.
	logic [ENTRY_W-1:0] node_val    [CAP];
	logic [IDX_W-1:0]   node_next   [CAP];
	logic [IDX_W-1:0]   spare_slots [CAP];
	logic [COUNT_W-1:0] spare_top;
	logic [IDX_W-1:0]   head_slot;
	logic [IDX_W-1:0]   tail_slot;
	logic [COUNT_W-1:0] held;

	// Replies predicted but not yet seen, oldest first.
	result_t list_replies [$];

	int fault_count;
	int quiet_cycles;
	bit tx_idle_en;     // sender inserts random gaps
	bit rx_idle_en;     // receiver drops ready in random bursts
	bit hold_out_req;   // receiver holds ready low once for HOLD_CYCLES

	circular_list_engine #(
		.CAPACITY   (CAP),
		.VALUE_BITS (ENTRY_W)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.item_value  (item_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.entry_value (entry_value),
		.last        (last),
		.entry_count (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// List shadow
	// ------------------------------------------------------------------
	function automatic void list_reset();
		for (int i = 0; i < CAP; i++) begin
			spare_slots[i] = IDX_W'(i);
			node_val[i]    = '0;
			node_next[i]   = '0;
		end
		spare_top = COUNT_W'(CAP);
		head_slot = '0;
		tail_slot = '0;
		held      = '0;
	endfunction

	// Count is sampled when the reply is queued, i.e. after the update.
	function automatic void push_reply(status_t st, logic [ENTRY_W-1:0] v, logic fin);
		result_t r;
		r.status = st;
		r.value  = v;
		r.last   = fin;
		r.count  = held;
		list_replies.push_back(r);
	endfunction

	// Apply one accepted transaction to the shadow and queue its replies.
	function automatic void list_apply(req_t kind, logic [ENTRY_W-1:0] v);
		logic [IDX_W-1:0] s;
		logic [IDX_W-1:0] prev;
		logic [IDX_W-1:0] cur;
		bit               found;
		int               i;
		case (kind)
			REQ_INS_FRONT, REQ_INS_END: begin
				if (spare_top == 0 || held >= CAP) begin
					// full store: refused, nothing moves
					push_reply(STS_FULL, '0, 1'b1);
				end else begin
					spare_top = spare_top - 1'b1;
					s = spare_slots[spare_top[IDX_W-1:0]];
					node_val[s] = v;
					if (held == 0) begin
						node_next[s] = s;
						head_slot    = s;
						tail_slot    = s;
					end else begin
						// new node always closes the ring behind the tail
						node_next[s]         = head_slot;
						node_next[tail_slot] = s;
						if (kind == REQ_INS_FRONT)
							head_slot = s;
						else
							tail_slot = s;
					end
					held = held + 1'b1;
					push_reply(STS_OK, '0, 1'b1);
				end
			end
			REQ_DELETE: begin
				prev  = tail_slot;
				cur   = head_slot;
				found = 1'b0;
				i     = 0;
				while (!found && i < held) begin
					if (node_val[cur] == v) begin
						found = 1'b1;
					end else begin
						prev = cur;
						cur  = node_next[cur];
						i++;
					end
				end
				if (!found) begin
					push_reply(STS_NOT_FOUND, '0, 1'b1);
				end else begin
					if (held == 1) begin
						// last entry gone: pointers fall back to slot zero
						head_slot = '0;
						tail_slot = '0;
					end else begin
						node_next[prev] = node_next[cur];
						if (cur == head_slot)
							head_slot = node_next[cur];
						if (cur == tail_slot)
							tail_slot = prev;
					end
					if (spare_top < CAP) begin
						spare_slots[spare_top[IDX_W-1:0]] = cur;
						spare_top = spare_top + 1'b1;
					end
					held = held - 1'b1;
					push_reply(STS_OK, '0, 1'b1);
				end
			end
			default: begin
				if (held == 0) begin
					push_reply(STS_EMPTY, '0, 1'b1);
				end else begin
					cur = head_slot;
					for (i = 0; i < held; i++) begin
						push_reply(STS_OK, node_val[cur], (i + 1) == held);
						cur = node_next[cur];
					end
				end
			end
		endcase
	endfunction

	// Mix of small values (duplicates), the signed extremes, and full range.
	function automatic logic [ENTRY_W-1:0] rand_value();
		case ($urandom_range(0, 3))
			0: return 32'($urandom_range(0, 6)) - 32'd3;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	// Value of a random entry currently on the list (list must be non-empty).
	function automatic logic [ENTRY_W-1:0] pick_listed();
		logic [IDX_W-1:0] cur;
		int               steps;
		cur   = head_slot;
		steps = $urandom_range(0, held - 1);
		repeat (steps) cur = node_next[cur];
		return node_val[cur];
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------
	// Drive at the falling edge, wait for the accepting rising edge, then
	// predict. Valid stays high between back-to-back calls, so it is never
	// dropped and raised within one time step.
	task automatic send_req(input req_t kind, input logic [ENTRY_W-1:0] v);
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		in_valid   = 1'b1;
		req_type   = kind;
		item_value = v;
		do @(posedge clk); while (!in_ready);
		list_apply(kind, v);
	endtask

	// Stop offering and wait for every queued reply to come back.
	task automatic wait_drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (list_replies.size() != 0) @(posedge clk);
	endtask

	// One random transaction; ins_pct steers the list toward full or empty.
	// Most deletes target a value on the list so that they hit.
	task automatic random_req(input int ins_pct);
		int                 roll;
		logic [ENTRY_W-1:0] v;
		roll = $urandom_range(0, 99);
		if (roll < ins_pct) begin
			send_req($urandom_range(0, 1) ? REQ_INS_FRONT : REQ_INS_END, rand_value());
		end else if (roll < ins_pct + 12) begin
			send_req(REQ_DUMP, $urandom());
		end else begin
			if (held != 0 && $urandom_range(0, 3) != 0)
				v = pick_listed();
			else
				v = rand_value();
			send_req(REQ_DELETE, v);
		end
	endtask

	// ------------------------------------------------------------------
	// Reply side
	// ------------------------------------------------------------------
	// Ready changes only at the falling edge. A long hold is counted here,
	// independently of the sender, so the engine backs up into its input.
	initial begin : reply_sink
		int hold_cnt;
		bit hold_taken;
		hold_taken = 1'b0;
		out_ready  = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_out_req && !hold_taken) begin
				out_ready = 1'b0;
				for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
					@(negedge clk);
				hold_taken = 1'b1;
				out_ready  = 1'b1;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_ready = 1'b1;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Compare each reply taken with the oldest prediction.
	always @(posedge clk) begin : reply_check
		result_t seen;
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			seen.status = status_t'(status);
			seen.value  = entry_value;
			seen.last   = last;
			seen.count  = entry_count;
			if (list_replies.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_MAX)
					$display("unexpected reply: status %0d value %0d last %0d count %0d",
						status, entry_value, last, entry_count);
			end else begin
				want = list_replies.pop_front();
				if (seen !== want) begin
					fault_count++;
					if (fault_count <= REPORT_MAX)
						$display({"reply mismatch: expected status %0d value %0d last %0d ",
							"count %0d, got status %0d value %0d last %0d count %0d"},
							want.status, want.value, want.last, want.count,
							status, entry_value, last, entry_count);
				end
			end
		end
	end

	// Watchdog: too long without a transaction on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Empty-list replies, single-entry delete, signed extremes, duplicates,
	// head/middle/tail removal, misses, and every bit of the value toggled.
	task automatic test_directed();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		send_req(REQ_DUMP,      32'h0000_0000);   // empty dump
		send_req(REQ_DELETE,    32'h0000_0000);   // delete on empty list
		send_req(REQ_INS_END,   32'h0000_0005);
		send_req(REQ_DELETE,    32'h0000_0005);   // only entry removed
		send_req(REQ_DUMP,      32'hFFFF_FFFF);
		send_req(REQ_INS_FRONT, 32'h8000_0000);
		send_req(REQ_INS_END,   32'h7FFF_FFFF);
		send_req(REQ_INS_FRONT, 32'h0000_0000);
		send_req(REQ_INS_END,   32'hFFFF_FFFF);
		send_req(REQ_INS_FRONT, 32'h0000_0007);
		send_req(REQ_INS_END,   32'h0000_0007);   // duplicate at the tail
		send_req(REQ_DUMP,      32'h0000_0000);
		send_req(REQ_DELETE,    32'h0000_0007);   // nearest the head goes
		send_req(REQ_DELETE,    32'h7FFF_FFFF);   // middle entry
		send_req(REQ_DELETE,    32'h1234_5678);   // miss
		send_req(REQ_DELETE,    32'h0000_0007);   // now the tail
		send_req(REQ_DUMP,      32'h0000_0000);
		send_req(REQ_DELETE,    32'h8000_0000);
		send_req(REQ_DELETE,    32'h0000_0000);
		send_req(REQ_DELETE,    32'hFFFF_FFFF);
		send_req(REQ_DUMP,      32'hFFFF_FFFF);
		send_req(REQ_INS_FRONT, 32'h5555_5555);
		send_req(REQ_INS_END,   32'hAAAA_AAAA);
		send_req(REQ_DUMP,      32'h0000_0000);
		send_req(REQ_DELETE,    32'hAAAA_AAAA);
		send_req(REQ_DELETE,    32'h5555_5555);
		wait_drain();
	endtask

	// Receiver stalls for a long stretch while inserts keep coming; the
	// engine backs up, then the list fills, two inserts are refused, and a
	// full dump follows.
	task automatic test_stall_fill();
		hold_out_req = 1'b1;
		repeat (CAP + 2)
			send_req($urandom_range(0, 1) ? REQ_INS_FRONT : REQ_INS_END, rand_value());
		send_req(REQ_DUMP, $urandom());
		wait_drain();
	endtask

	// Alternating grow and shrink phases, with idling switched per phase so
	// that some stretches run without gaps; one drain pause midway.
	task automatic test_random_mix();
		for (int phase = 0; phase < 6; phase++) begin
			tx_idle_en = (phase % 3) != 2;
			rx_idle_en = (phase % 3) != 1;
			repeat (32) random_req((phase % 2 == 0) ? 70 : 25);
			if (phase == 2)
				wait_drain();
		end
	endtask

	// Closing stretch at full rate on both sides.
	task automatic test_full_rate_tail();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		repeat (30) random_req(45);
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		req_type     = REQ_INS_FRONT;
		item_value   = '0;
		tx_idle_en   = 1'b0;
		rx_idle_en   = 1'b0;
		hold_out_req = 1'b0;
		list_reset();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_stall_fill();
		test_random_mix();
		test_full_rate_tail();

		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0 && list_replies.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* circular_list_engine.f */
rtl/clist_pkg.sv
rtl/clist_node_mem.sv
rtl/clist_free_stack.sv
rtl/clist_out_reg.sv
rtl/circular_list_engine.sv
bench/tb_circular_list_engine.sv
